### rtl/core/pdsr_pkg.sv
package pdsr_pkg;

  localparam int unsigned DEQUE_DEPTH = 1024;
  localparam int unsigned SLOT_W      = 10;   // local slot index
  localparam int unsigned CNT_W       = 11;   // head and tail counts
  localparam int unsigned TASK_W      = 232;  // {type, level, third, second, first}
  localparam int unsigned RES_W       = 64;   // {done, value}
  localparam int unsigned IN_DATA_W   = 328;
  localparam int unsigned OUT_DATA_W  = 328;

  typedef enum logic [3:0] {
    K_TRANSFER   = 4'd0,
    K_REFUSE     = 4'd1,
    K_EXEC_LOCAL = 4'd2,
    K_SYNC_VALUE = 4'd3,
    K_SYNC_PEND  = 4'd4,
    K_STEAL_ACC  = 4'd5,
    K_STEAL_BLK  = 4'd6,
    K_STEAL_BUSY = 4'd7,
    K_OVERFLOW   = 4'd8,
    K_UNDERFLOW  = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    M_SPAWN    = 3'd0,
    M_SYNC     = 3'd1,
    M_STEAL    = 3'd2,
    M_PROGRESS = 3'd3,
    M_DONE     = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    MB_EMPTY = 2'd0,
    MB_OCC   = 2'd1,
    MB_BLOCK = 2'd2
  } mbox_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POLL_OUT,
    S_SYNC_RD,
    S_SYNC_OUT
  } state_t;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_BASE      = 1'b1
  } cfg_idx_t;

  // request from the control fsm to the slot store
  typedef struct packed {
    logic              task_we;
    logic              res_we;
    logic [SLOT_W-1:0] wr_addr;
    logic [SLOT_W-1:0] res_addr;
    logic [TASK_W-1:0] task_wdata;
    logic [RES_W-1:0]  res_wdata;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } mem_req_t;

endpackage

### rtl/core/pdsr_slot_store.sv
module pdsr_slot_store
  import pdsr_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [TASK_W-1:0] rd_task,
  output logic [RES_W-1:0]  rd_res
);

  logic [TASK_W-1:0] task_mem [DEQUE_DEPTH];
  logic [RES_W-1:0]  res_mem  [DEQUE_DEPTH];
  logic [TASK_W-1:0] rd_task_r;
  logic [RES_W-1:0]  rd_res_r;

  always_ff @(posedge clk) begin
    if (req.task_we) begin
      task_mem[req.wr_addr] <= req.task_wdata;
    end
    if (req.res_we) begin
      res_mem[req.res_addr] <= req.res_wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_task_r <= task_mem[req.rd_addr];
      rd_res_r  <= res_mem[req.rd_addr];
    end
  end

  assign rd_task = rd_task_r;
  assign rd_res  = rd_res_r;

endmodule

### rtl/core/private_deque_steal_responder_core.sv
// Owner side of a private work-stealing task deque with a one-slot steal
// request mailbox. Requests enter on in_* (tuser = mode), results leave on
// out_* (tuser = kind, tlast on the final result of a request). Task slots
// and stolen-task results live in two single-port-read synchronous memories
// of 1024 entries; slots below the head count are exactly the stolen ones,
// so no per-slot stolen flag and no clearing pass after reset are needed.
// Spawn, steal and done requests finish in the idle state. A progress poll
// also passes through S_POLL_OUT when it hands the head task to a thief (one
// memory read). A sync runs its poll, then a read of the tail slot.
// One request is worked on at a time; a result waiting in the output
// register holds off the next request until the cycle in which it is taken,
// and each result that waits adds its stall cycles to the request. 
// Configuration is taken at any cycle on cfg_* and must only change while
// the block is idle.
module private_deque_steal_responder_core
  import pdsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // stream in
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata low to high: task_type, arg_first, arg_second, arg_third,
  // task_level, requester_id, done_slot, done_value, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [2:0]            in_tuser,    // mode
  // stream out
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata low to high: target_thread, out_type, out_first, out_second,
  // out_third, out_level, out_slot, sync_value, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [3:0]            out_tuser,   // kind
  output logic                  out_tlast,   // last
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [23:0]           cfg_data
);

  // input field unpacking
  logic [7:0]  in_type;
  logic [63:0] in_first, in_second, in_third;
  logic [31:0] in_level;
  logic [5:0]  in_req;
  logic [23:0] in_done_slot;
  logic [62:0] in_done_value;

  assign in_type       = in_tdata[7:0];
  assign in_first      = in_tdata[71:8];
  assign in_second     = in_tdata[135:72];
  assign in_third      = in_tdata[199:136];
  assign in_level      = in_tdata[231:200];
  assign in_req        = in_tdata[237:232];
  assign in_done_slot  = in_tdata[261:238];
  assign in_done_value = in_tdata[324:262];

  // control and config state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  tail_r, tail_nxt;
  mbox_t             mb_r, mb_nxt;
  logic [5:0]        thief_r, thief_nxt;
  logic              sync_r, sync_nxt;     // a sync follows the pending poll
  logic [CNT_W-1:0]  thr_r;
  logic [23:0]       base_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic              out_last_r, out_last_nxt;
  logic [5:0]        out_thr_r, out_thr_nxt;
  logic [TASK_W-1:0] out_task_r, out_task_nxt;
  logic [23:0]       out_slot_r, out_slot_nxt;
  logic [62:0]       out_val_r, out_val_nxt;

  mem_req_t          mreq;
  logic [TASK_W-1:0] rd_task;
  logic [RES_W-1:0]  rd_res;

  pdsr_slot_store u_store (
    .clk     (clk),
    .req     (mreq),
    .rd_task (rd_task),
    .rd_res  (rd_res)
  );

  // config port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= CNT_W'(2);
      base_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: thr_r  <= cfg_data[CNT_W-1:0];
        CFG_BASE:      base_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // derived values
  logic              ofree;
  logic [CNT_W-1:0]  avail;
  logic              below;
  logic [CNT_W-1:0]  pop_idx;
  logic [23:0]       done_loc;
  logic              done_hit;
  logic              in_acc;

  assign ofree    = !out_valid_r || out_tready;
  assign avail    = tail_r - head_r;
  // nothing queued always counts as below threshold
  assign below    = (avail < thr_r) || (avail == '0);
  assign pop_idx  = tail_r - CNT_W'(1);
  assign done_loc = in_done_slot - base_r;
  // stolen slots are exactly those below head
  assign done_hit = (done_loc[23:SLOT_W] == '0) && ({1'b0, done_loc[SLOT_W-1:0]} < head_r);
  assign in_tready = (state_r == S_IDLE) && ofree;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    mb_nxt        = mb_r;
    thief_nxt     = thief_r;
    sync_nxt      = sync_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_thr_nxt   = out_thr_r;
    out_task_nxt  = out_task_r;
    out_slot_nxt  = out_slot_r;
    out_val_nxt   = out_val_r;

    mreq            = '0;
    mreq.wr_addr    = tail_r[SLOT_W-1:0];
    mreq.res_addr   = tail_r[SLOT_W-1:0];
    mreq.task_wdata = {in_type, in_level, in_third, in_second, in_first};
    mreq.rd_addr    = head_r[SLOT_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            M_SPAWN: begin
              if (tail_r >= CNT_W'(DEQUE_DEPTH - 1)) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = K_OVERFLOW;
                out_last_nxt  = 1'b1;
                out_thr_nxt   = '0;
                out_task_nxt  = '0;
                out_slot_nxt  = '0;
                out_val_nxt   = '0;
              end else begin
                // new slot is local and has no reported value
                mreq.task_we   = 1'b1;
                mreq.res_we    = 1'b1;
                mreq.res_wdata = '0;
                tail_nxt       = tail_r + CNT_W'(1);
              end
            end
            M_STEAL: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              out_thr_nxt   = in_req;
              out_task_nxt  = '0;
              out_slot_nxt  = '0;
              out_val_nxt   = '0;
              // every 6-bit requester is below the thread limit
              unique case (mb_r)
                MB_EMPTY: begin
                  out_kind_nxt = K_STEAL_ACC;
                  mb_nxt       = MB_OCC;
                  thief_nxt    = in_req;
                end
                MB_BLOCK: out_kind_nxt = K_STEAL_BLK;
                default:  out_kind_nxt = K_STEAL_BUSY;
              endcase
            end
            M_DONE: begin
              if (done_hit) begin
                mreq.res_we    = 1'b1;
                mreq.res_addr  = done_loc[SLOT_W-1:0];
                mreq.res_wdata = {1'b1, in_done_value};
              end
            end
            M_SYNC, M_PROGRESS: begin
              sync_nxt  = (in_tuser == M_SYNC);
              state_nxt = (in_tuser == M_SYNC) ? S_SYNC_RD : S_IDLE;
              if (below) begin
                mb_nxt = MB_BLOCK;
                if (mb_r == MB_OCC) begin
                  out_valid_nxt = 1'b1;
                  out_kind_nxt  = K_REFUSE;
                  out_last_nxt  = (in_tuser != M_SYNC);
                  out_thr_nxt   = thief_r;
                  out_task_nxt  = '0;
                  out_slot_nxt  = '0;
                  out_val_nxt   = '0;
                end
              end else if (mb_r == MB_BLOCK) begin
                mb_nxt = MB_EMPTY;
              end else if (mb_r == MB_OCC) begin
                // fetch the head task for the thief
                mreq.rd_en = 1'b1;
                mb_nxt     = MB_EMPTY;
                state_nxt  = S_POLL_OUT;
              end
            end
            default: ;
          endcase
        end
      end

      S_POLL_OUT: begin
        if (ofree) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_TRANSFER;
          out_last_nxt  = !sync_r;
          out_thr_nxt   = thief_r;
          out_task_nxt  = rd_task;
          out_slot_nxt  = base_r + 24'(head_r);
          out_val_nxt   = '0;
          head_nxt      = head_r + CNT_W'(1);
          state_nxt     = sync_r ? S_SYNC_RD : S_IDLE;
        end
      end

      S_SYNC_RD: begin
        if (tail_r == '0) begin
          if (ofree) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = K_UNDERFLOW;
            out_last_nxt  = 1'b1;
            out_thr_nxt   = '0;
            out_task_nxt  = '0;
            out_slot_nxt  = '0;
            out_val_nxt   = '0;
            state_nxt     = S_IDLE;
          end
        end else begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = pop_idx[SLOT_W-1:0];
          state_nxt    = S_SYNC_OUT;
        end
      end

      S_SYNC_OUT: begin
        if (ofree) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_thr_nxt   = '0;
          out_task_nxt  = '0;
          out_slot_nxt  = '0;
          out_val_nxt   = '0;
          state_nxt     = S_IDLE;
          if (pop_idx < head_r) begin
            // stolen tail slot: it is the one just below head
            if (rd_res[RES_W-1]) begin
              out_kind_nxt = K_SYNC_VALUE;
              out_val_nxt  = rd_res[62:0];
              head_nxt     = (head_r != '0) ? head_r - CNT_W'(1) : head_r;
              tail_nxt     = pop_idx;
            end else begin
              out_kind_nxt = K_SYNC_PEND;
            end
          end else begin
            out_kind_nxt = K_EXEC_LOCAL;
            out_task_nxt = rd_task;
            tail_nxt     = pop_idx;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      mb_r        <= MB_EMPTY;
      thief_r     <= '0;
      sync_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      mb_r        <= mb_nxt;
      thief_r     <= thief_nxt;
      sync_r      <= sync_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_thr_r  <= out_thr_nxt;
    out_task_r <= out_task_nxt;
    out_slot_r <= out_slot_nxt;
    out_val_r  <= out_val_nxt;
  end

  // task word is {type, level, third, second, first}
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_val_r, out_slot_r,
                       out_task_r[223:192],   // level
                       out_task_r[191:0],     // third, second, first
                       out_task_r[231:224],   // type
                       out_thr_r};

  // head never passes tail
  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("head passed tail");

  // deque never grows past its last usable slot
  a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= CNT_W'(DEQUE_DEPTH - 1)) else $error("tail out of range");

  // a transfer always moves head by one
  a_transfer_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POLL_OUT && ofree) |=> (head_r == $past(head_r) + CNT_W'(1)))
    else $error("transfer did not advance head");

  // a transferred thief leaves the mailbox non-occupied
  a_poll_clears_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POLL_OUT) |-> (mb_r != MB_OCC)) else $error("mailbox still occupied");

endmodule

### tb/pdsr_checker.sv
module pdsr_checker
  import pdsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [2:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [3:0]            out_tuser,
  input  logic                  out_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [23:0]           cfg_data,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t       kind;
    logic [5:0]  thread;
    logic [7:0]  ttype;
    logic [63:0] first;
    logic [63:0] second;
    logic [63:0] third;
    logic [31:0] level;
    logic [23:0] gslot;
    logic [62:0] value;
    logic        last;
  } result_t;

  result_t     results_due[$];
  logic [63:0] task_args[3*DEQUE_DEPTH];
  logic [39:0] task_type_level[DEQUE_DEPTH];
  bit          slot_taken[DEQUE_DEPTH];
  logic [63:0] task_result[DEQUE_DEPTH];
  int unsigned head, tail;
  mbox_t       mbox;
  logic [5:0]  mbox_thief;
  int unsigned threshold;
  logic [23:0] base;

  assign pending = results_due.size();

  task automatic queue_result(kind_t k, logic [5:0] thr, int unsigned s, bit with_task,
                              logic [23:0] gs, logic [62:0] v);
    result_t r;
    r = '{kind: k, thread: thr, ttype: '0, first: '0, second: '0, third: '0, level: '0,
          gslot: gs, value: v, last: 1'b0};
    if (with_task) begin
      r.ttype  = task_type_level[s][39:32];
      r.level  = task_type_level[s][31:0];
      r.first  = task_args[3*s];
      r.second = task_args[3*s+1];
      r.third  = task_args[3*s+2];
    end
    results_due.push_back(r);
  endtask

  // mailbox service run by progress and at the head of sync
  task automatic service_mailbox();
    int unsigned avail;
    avail = tail - head;
    if (avail < threshold || avail == 0) begin
      if (mbox == MB_OCC) queue_result(K_REFUSE, mbox_thief, 0, 0, '0, '0);
      mbox = MB_BLOCK;
    end else if (mbox == MB_BLOCK) begin
      mbox = MB_EMPTY;
    end else if (mbox == MB_OCC && head < DEQUE_DEPTH) begin
      mbox = MB_EMPTY;
      slot_taken[head] = 1'b1;
      queue_result(K_TRANSFER, mbox_thief, head, 1, 24'(base + head), '0);
      head++;
    end
  endtask

  task automatic predict_request(logic [2:0] mode, logic [IN_DATA_W-1:0] d);
    int          n0;
    int unsigned p;
    logic [23:0] loc;
    n0 = results_due.size();
    case (mode)
      M_SPAWN: begin
        if (tail >= DEQUE_DEPTH - 1) begin
          queue_result(K_OVERFLOW, '0, 0, 0, '0, '0);
        end else begin
          task_type_level[tail] = {d[7:0], d[231:200]};
          task_args[3*tail]     = d[71:8];
          task_args[3*tail+1]   = d[135:72];
          task_args[3*tail+2]   = d[199:136];
          task_result[tail]     = '0;
          slot_taken[tail]      = 1'b0;
          tail++;
        end
      end
      M_SYNC: begin
        service_mailbox();
        if (tail == 0) begin
          queue_result(K_UNDERFLOW, '0, 0, 0, '0, '0);
        end else begin
          p = tail - 1;
          if (slot_taken[p]) begin
            if (task_result[p][63]) begin
              queue_result(K_SYNC_VALUE, '0, 0, 0, '0, task_result[p][62:0]);
              slot_taken[p] = 1'b0;
              if (head > 0) head--;
              tail = p;
            end else begin
              queue_result(K_SYNC_PEND, '0, 0, 0, '0, '0);
            end
          end else begin
            queue_result(K_EXEC_LOCAL, '0, p, 1, '0, '0);
            tail = p;
          end
        end
      end
      M_STEAL: begin
        if (mbox == MB_EMPTY) begin
          mbox       = MB_OCC;
          mbox_thief = d[237:232];
          queue_result(K_STEAL_ACC, d[237:232], 0, 0, '0, '0);
        end else if (mbox == MB_BLOCK) begin
          queue_result(K_STEAL_BLK, d[237:232], 0, 0, '0, '0);
        end else begin
          queue_result(K_STEAL_BUSY, d[237:232], 0, 0, '0, '0);
        end
      end
      M_PROGRESS: service_mailbox();
      M_DONE: begin
        loc = d[261:238] - base;
        if (loc < DEQUE_DEPTH && slot_taken[loc[9:0]])
          task_result[loc[9:0]] = {1'b1, d[324:262]};
      end
      default: ;
    endcase
    if (results_due.size() > n0) results_due[results_due.size()-1].last = 1'b1;
  endtask

  task automatic report(string name, logic [63:0] want, logic [63:0] got);
    $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
    errors++;
  endtask

  task automatic check_result();
    result_t e;
    if (results_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d data %h",
               $time, out_tuser, out_tdata);
      errors++;
      return;
    end
    e = results_due.pop_front();
    if (out_tuser        !== e.kind)   report("kind", e.kind, out_tuser);
    if (out_tdata[5:0]   !== e.thread) report("target_thread", e.thread, out_tdata[5:0]);
    if (out_tdata[13:6]  !== e.ttype)  report("out_type", e.ttype, out_tdata[13:6]);
    if (out_tdata[77:14] !== e.first)  report("out_first", e.first, out_tdata[77:14]);
    if (out_tdata[141:78] !== e.second) report("out_second", e.second, out_tdata[141:78]);
    if (out_tdata[205:142] !== e.third) report("out_third", e.third, out_tdata[205:142]);
    if (out_tdata[237:206] !== e.level) report("out_level", e.level, out_tdata[237:206]);
    if (out_tdata[261:238] !== e.gslot) report("out_slot", e.gslot, out_tdata[261:238]);
    if (out_tdata[324:262] !== e.value) report("sync_value", e.value, out_tdata[324:262]);
    if (out_tlast        !== e.last)   report("last", e.last, out_tlast);
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      head       = 0;
      tail       = 0;
      mbox       = MB_EMPTY;
      mbox_thief = '0;
      threshold  = 2;
      base       = '0;
      for (int i = 0; i < DEQUE_DEPTH; i++) slot_taken[i] = 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_THRESHOLD) threshold = cfg_data[10:0];
        else base = cfg_data;
      end
      if (in_tvalid && in_tready) predict_request(in_tuser, in_tdata);
    end
  end
endmodule

### tb/testbench.sv
module testbench;
  import pdsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [2:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [3:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic [23:0]           cfg_data = '0;
  int                    errors;
  int                    pending;

  // stimulus state
  bit          quiet = 1'b0;      // no idling on either side
  int          hold_req = 0;      // bumped to ask the receiver for a long hold-off
  int          hold_seen = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  logic [23:0] cur_base = '0;

  always #4 clk = ~clk;

  private_deque_steal_responder_core DUT (.*);

  pdsr_checker u_checker (.*);

  // receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen  <= hold_req;
      stall_left <= 300;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one request on the input stream, with an optional gap in front
  task automatic send_request(logic [2:0] mode, logic [IN_DATA_W-1:0] data);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [IN_DATA_W-1:0] pack_request(logic [7:0] ttype, logic [63:0] a,
      logic [63:0] b, logic [63:0] c, logic [31:0] lvl, logic [5:0] thief,
      logic [23:0] dslot, logic [62:0] dval);
    return {3'b000, dval, dslot, thief, lvl, c, b, a, ttype};
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_request(bit near_slot);
    logic [23:0] dslot;
    dslot = near_slot ? 24'(cur_base + $urandom_range(0, 15)) : 24'($urandom);
    return pack_request(8'($urandom), rand64(), rand64(), rand64(), $urandom,
                        6'($urandom), dslot, 63'(rand64()));
  endfunction

  task automatic spawn_task(logic [7:0] ttype, logic [63:0] a, logic [31:0] lvl);
    send_request(M_SPAWN, pack_request(ttype, a, ~a, a ^ 64'h5a5a, lvl, '0, '0, '0));
  endtask

  task automatic simple_request(logic [2:0] mode, logic [5:0] thief, logic [23:0] dslot,
                                logic [62:0] dval);
    send_request(mode, pack_request('0, '0, '0, '0, '0, thief, dslot, dval));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // a request with no result may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_BASE) cur_base = value;
  endtask

  // weighted random mix; spawn_pct steers how fast the deque grows
  task automatic random_phase(int count, int spawn_pct);
    int          pick;
    logic [2:0]  mode;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < spawn_pct) mode = M_SPAWN;
      else begin
        pick = $urandom_range(0, 99);
        if (pick < 30) mode = M_SYNC;
        else if (pick < 52) mode = M_STEAL;
        else if (pick < 74) mode = M_PROGRESS;
        else if (pick < 95) mode = M_DONE;
        else mode = 3'($urandom_range(5, 7));
      end
      send_request(mode, random_request($urandom_range(0, 9) < 8));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, threshold 2 and base 0
    simple_request(M_SYNC, '0, '0, '0);                  // empty sync, mailbox blocks
    simple_request(M_STEAL, 6'd63, '0, '0);              // blocked steal
    send_request(M_SPAWN, '0);
    send_request(M_SPAWN, pack_request('1, '1, '1, '1, '1, '1, '1, '1));
    spawn_task(8'h3c, 64'h0123_4567_89ab_cdef, 32'h8000_0001);
    simple_request(M_PROGRESS, '0, '0, '0);              // unblock mailbox
    simple_request(M_STEAL, 6'd0, '0, '0);               // accepted
    simple_request(M_STEAL, 6'd5, '0, '0);               // busy
    simple_request(M_PROGRESS, '0, '0, '0);              // head task handed over
    simple_request(M_DONE, '0, 24'd0, '1);               // stolen slot reports
    simple_request(M_DONE, '0, 24'd5, 63'd7);            // slot not stolen
    simple_request(M_DONE, '0, 24'hff_ffff, 63'd9);      // slot out of range
    simple_request(3'd5, '0, '0, '0);
    simple_request(3'd6, '0, '0, '0);
    simple_request(3'd7, '0, '0, '0);
    simple_request(M_SYNC, '0, '0, '0);                  // local pop
    simple_request(M_SYNC, '0, '0, '0);                  // local pop, mailbox blocks
    simple_request(M_SYNC, '0, '0, '0);                  // stolen slot returns value
    simple_request(M_SYNC, '0, '0, '0);                  // empty again
    spawn_task(8'h11, 64'h1, 32'd1);
    spawn_task(8'h22, 64'h2, 32'd2);
    simple_request(M_PROGRESS, '0, '0, '0);
    simple_request(M_STEAL, 6'd9, '0, '0);
    simple_request(M_SYNC, '0, '0, '0);                  // transfer then local pop
    simple_request(M_SYNC, '0, '0, '0);
    drain_results();

    // threshold 0, highest base
    write_register(CFG_THRESHOLD, 24'd0);
    write_register(CFG_BASE, 24'd16776192);
    random_phase(150, 35);
    drain_results();

    // deque fills up to overflow; receiver holds off while the sender keeps going
    write_register(CFG_THRESHOLD, 24'd3);
    write_register(CFG_BASE, 24'($urandom));
    random_phase(100, 90);
    hold_req++;
    random_phase(1200, 90);
    // sender waits for every outstanding result
    drain_results();

    // every poll blocks the mailbox, so later steal requests are blocked
    write_register(CFG_THRESHOLD, 24'd1024);
    write_register(CFG_BASE, '0);
    random_phase(120, 30);
    drain_results();

    // threshold back to reset value, no idling at the end
    write_register(CFG_THRESHOLD, 24'd2);
    write_register(CFG_BASE, 24'd1000);
    random_phase(60, 35);
    quiet = 1'b1;
    random_phase(150, 35);
    in_tvalid <= 1'b0;

    fork
      begin
        do @(posedge clk); while (pending != 0);
      end
      begin
        repeat (50000) @(posedge clk);
      end
    join_any
    disable fork;
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
